// ===== hw/rtl/sbphd_pkg.sv =====
// ============================================================================
// sbphd_pkg - spectrum bar peak hold package
// Beat types, register indexes and the fixed rate tables of the bar meter.
// ============================================================================
package sbphd_pkg;

    // Configuration port widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_FALL  = 2'd0,
        CFG_PEAK_FALL   = 2'd1,
        CFG_REDRAW_RATE = 2'd2
    } cfg_reg_t;

    // Level fall rate numerators, in hundredths of one bar unit
    localparam int unsigned FALL_NUM_0 = 34;
    localparam int unsigned FALL_NUM_1 = 50;
    localparam int unsigned FALL_NUM_2 = 100;
    localparam int unsigned FALL_NUM_3 = 130;
    localparam int unsigned FALL_NUM_4 = 160;

    // Rounding offset and divisor of the hundredths arithmetic
    localparam int unsigned HUNDRED      = 100;
    localparam int unsigned HALF_HUNDRED = 50;

    typedef struct packed {
        logic [6:0] bar_index;
        logic [7:0] new_level;
        logic       level_valid;
        logic       decay_tick;
        logic       frame_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] bar_height;
        logic [7:0] peak_height;
        logic       redraw_request;
    } out_item_t;

    // Peak speed growth factor in hundredths; selects above four saturate
    function automatic logic [7:0] grow_num(input logic [2:0] sel);
        logic [7:0] g;
        case (sel)
            3'd0:    g = 8'd120;
            3'd1:    g = 8'd130;
            3'd2:    g = 8'd140;
            3'd3:    g = 8'd150;
            default: g = 8'd160;
        endcase
        return g;
    endfunction

    // Redraw delay in frame-end ticks
    function automatic logic [3:0] redraw_delay(input logic [1:0] sel);
        logic [3:0] d;
        case (sel)
            2'd0:    d = 4'd1;
            2'd1:    d = 4'd2;
            2'd2:    d = 4'd4;
            default: d = 4'd8;
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/sbphd_store.sv =====
// ============================================================================
// sbphd_store - per-bar state memory
// Single-port-write, registered-read memory with per-entry valid bits and a
// bypass from the most recent write onto the read data.
// ============================================================================
module sbphd_store #(
    parameter int DEPTH  = 75,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 60
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] mem_q_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              rd_vld_reg;
    logic [DEPTH-1:0]  vld_reg;
    logic              wb_valid_reg;
    logic [ADDR_W-1:0] wb_addr_reg;
    logic [DATA_W-1:0] wb_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q_reg   <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (wr_en)
        begin
            wb_addr_reg <= wr_addr;
            wb_data_reg <= wr_data;
        end
    end

    // Unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
                wb_valid_reg     <= 1'b1;
            end
        end
    end

    // A write on the read edge is missed by the array; take it from the bypass
    always_comb
    begin
        if (wb_valid_reg && (wb_addr_reg == rd_addr_reg))
        begin
            rd_data = wb_data_reg;
        end
        else if (rd_vld_reg)
        begin
            rd_data = mem_q_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

// ===== hw/rtl/spectrum_bar_peak_hold_decay_top.sv =====
// ============================================================================
// spectrum_bar_peak_hold_decay_top - bar meter with peak hold and falloff
// Per-bar level, peak and peak speed held in one memory; each beat does a
// read-modify-write of its bar and returns the new integer heights.
// ============================================================================
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   in      | into      | in_valid/in_stall  | in_data  (bar, level, flags)
//   out     | out of    | out_valid/out_stall| out_data (heights, redraw)
//   cfg     | into      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One beat per cycle while in_stall is low. A result passes stage 1, stage 2
// and the output register after its beat is taken. A beat for the same bar as
// stage 1 waits for that beat's peak speed, set by the reciprocal divide stage.
// Reset clears the per-bar valid bits at once, so no clearing pass is needed.
// A stalled result freezes the whole pipeline; in_stall follows it.
//
module spectrum_bar_peak_hold_decay_top #(
    parameter int NUM_BARS  = 75,
    parameter int FRAC_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  sbphd_pkg::in_item_t                in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output sbphd_pkg::out_item_t               out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sbphd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbphd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sbphd_pkg::*;

    // Q8.FRAC_BITS values and derived sizes
    localparam int QW     = 8 + FRAC_BITS;
    localparam int PW     = QW + 8;           // speed times growth factor
    localparam int DW     = 3 * QW;           // level, peak, speed
    localparam int ADDR_W = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;
    localparam int RSH    = PW + 7;           // reciprocal shift, exact for PW bits
    localparam int NW     = 2 * PW + 1 - RSH; // grown speed before saturation

    localparam logic [QW-1:0] QMAX = {QW{1'b1}};
    localparam logic [63:0]   QONE = 64'd1 << FRAC_BITS;
    localparam logic [QW-1:0] SPEED_INIT =
        QW'((QONE + 64'(HALF_HUNDRED)) / 64'(HUNDRED));
    localparam logic [QW-1:0] FALL_RATE_0 =
        QW'((64'(FALL_NUM_0) * QONE + 64'(HALF_HUNDRED)) / 64'(HUNDRED));
    localparam logic [QW-1:0] FALL_RATE_1 =
        QW'((64'(FALL_NUM_1) * QONE + 64'(HALF_HUNDRED)) / 64'(HUNDRED));
    localparam logic [QW-1:0] FALL_RATE_2 =
        QW'((64'(FALL_NUM_2) * QONE + 64'(HALF_HUNDRED)) / 64'(HUNDRED));
    localparam logic [QW-1:0] FALL_RATE_3 =
        QW'((64'(FALL_NUM_3) * QONE + 64'(HALF_HUNDRED)) / 64'(HUNDRED));
    localparam logic [QW-1:0] FALL_RATE_4 =
        QW'((64'(FALL_NUM_4) * QONE + 64'(HALF_HUNDRED)) / 64'(HUNDRED));
    localparam logic [63:0] RECIP64 =
        ((64'd1 << RSH) + 64'(HUNDRED) - 64'd1) / 64'(HUNDRED);
    localparam logic [PW:0] RECIP = RECIP64[PW:0];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0] level_fall_sel_reg;
    logic [2:0] peak_fall_sel_reg;
    logic [1:0] redraw_rate_sel_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_fall_sel_reg  <= '0;
            peak_fall_sel_reg   <= '0;
            redraw_rate_sel_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LEVEL_FALL:  level_fall_sel_reg  <= cfg_data[2:0];
                CFG_PEAK_FALL:   peak_fall_sel_reg   <= cfg_data[2:0];
                CFG_REDRAW_RATE: redraw_rate_sel_reg <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              out_valid_reg;
    logic              adv;
    logic              hazard;
    logic              accept;
    logic [8:0]        in_idx;
    logic              in_inr;
    logic [ADDR_W-1:0] in_addr;

    assign in_idx  = {2'b00, in_data.bar_index};
    assign in_inr  = (in_idx < 9'(NUM_BARS));
    assign in_addr = in_idx[ADDR_W-1:0];

    // Whole pipeline moves unless the output holds a beat that is stalled
    assign adv = !out_valid_reg || !out_stall;

    // Same bar right behind: its speed is still in the divide stage
    logic              s1_inr_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    assign hazard   = s1_valid_reg && s1_inr_reg && in_inr && (s1_addr_reg == in_addr);
    assign in_stall = !adv || hazard;
    assign accept   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Bar store
    // ------------------------------------------------------------------
    logic [DW-1:0]     cur;
    logic              wr_en;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [DW-1:0]     wr_data;
    logic              s2_inr_reg;

    assign wr_en = adv && s2_valid_reg && s2_inr_reg;

    sbphd_store #(
        .DEPTH  (NUM_BARS),
        .ADDR_W (ADDR_W),
        .DATA_W (DW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_inr),
        .rd_addr (in_addr),
        .wr_en   (wr_en),
        .wr_addr (s2_addr_reg),
        .wr_data (wr_data),
        .rd_data (cur)
    );

    // ------------------------------------------------------------------
    // Stage 1: level and peak update, speed product
    // ------------------------------------------------------------------
    logic [7:0]    s1_new_level_reg;
    logic          s1_level_valid_reg;
    logic          s1_tick_reg;
    logic          s1_last_reg;
    logic [3:0]    cd_reg;

    logic [QW-1:0] cur_lvl;
    logic [QW-1:0] cur_pk;
    logic [QW-1:0] cur_spd;
    logic [QW-1:0] nl_q;
    logic [QW-1:0] fall_rate;
    logic [QW-1:0] pk_sub;
    logic          do_decay;
    logic [QW-1:0] lvl_next;
    logic [QW-1:0] pk_next;
    logic [QW-1:0] spd_next;
    logic          grow_next;
    logic [PW-1:0] prod_next;
    logic          redraw_next;
    logic [3:0]    cd_load;
    logic [3:0]    cd_next;

    assign cur_lvl = cur[DW-1 -: QW];
    assign cur_pk  = cur[2*QW-1 -: QW];
    assign cur_spd = cur[QW-1:0];
    assign nl_q    = {s1_new_level_reg, {FRAC_BITS{1'b0}}};
    assign pk_sub  = (cur_spd >= cur_pk) ? '0 : (cur_pk - cur_spd);

    always_comb
    begin
        case (level_fall_sel_reg)
            3'd0:    fall_rate = FALL_RATE_0;
            3'd1:    fall_rate = FALL_RATE_1;
            3'd2:    fall_rate = FALL_RATE_2;
            3'd3:    fall_rate = FALL_RATE_3;
            default: fall_rate = FALL_RATE_4;
        endcase
    end

    always_comb
    begin
        lvl_next  = cur_lvl;
        pk_next   = cur_pk;
        spd_next  = cur_spd;
        do_decay  = 1'b0;
        grow_next = 1'b0;
        if (s1_level_valid_reg && (nl_q > cur_lvl))
        begin
            lvl_next = nl_q;
            if (nl_q > cur_pk)
            begin
                pk_next  = nl_q;
                spd_next = SPEED_INIT;
            end
            else if (cur_pk != '0)
            begin
                do_decay = 1'b1;
            end
        end
        else if (s1_tick_reg)
        begin
            lvl_next = (fall_rate >= cur_lvl) ? '0 : (cur_lvl - fall_rate);
            if (cur_pk != '0)
            begin
                do_decay = 1'b1;
            end
        end
        // decayed peak is floored at the new level
        if (do_decay)
        begin
            pk_next   = (pk_sub < lvl_next) ? lvl_next : pk_sub;
            grow_next = 1'b1;
        end
    end

    assign prod_next = PW'(cur_spd) * PW'(grow_num(peak_fall_sel_reg))
                       + PW'(HALF_HUNDRED);

    // Redraw countdown, run in beat order
    always_comb
    begin
        redraw_next = 1'b0;
        cd_load     = cd_reg;
        cd_next     = cd_reg;
        if (s1_last_reg && s1_tick_reg)
        begin
            if (cd_reg == 4'd0)
            begin
                redraw_next = 1'b1;
                cd_load     = redraw_delay(redraw_rate_sel_reg);
            end
            cd_next = cd_load - 4'd1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: speed divide by 100 (reciprocal multiply), write back
    // ------------------------------------------------------------------
    logic [QW-1:0]     s2_lvl_reg;
    logic [QW-1:0]     s2_pk_reg;
    logic [QW-1:0]     s2_spd_reg;
    logic              s2_grow_reg;
    logic [PW-1:0]     s2_prod_reg;
    logic              s2_redraw_reg;
    logic [2*PW:0]     quot;
    logic [NW-1:0]     grown;
    logic [QW-1:0]     spd_sat;
    logic [QW-1:0]     spd_wr;
    out_item_t         out_next;
    out_item_t         out_reg;

    assign quot    = (2*PW+1)'(s2_prod_reg) * (2*PW+1)'(RECIP);
    assign grown   = quot[2*PW:RSH];
    assign spd_sat = (grown > NW'(QMAX)) ? QMAX : grown[QW-1:0];
    assign spd_wr  = s2_grow_reg ? spd_sat : s2_spd_reg;
    assign wr_data = {s2_lvl_reg, s2_pk_reg, spd_wr};

    always_comb
    begin
        out_next.bar_height     = s2_inr_reg ? s2_lvl_reg[QW-1:FRAC_BITS] : 8'd0;
        out_next.peak_height    = s2_inr_reg ? s2_pk_reg[QW-1:FRAC_BITS] : 8'd0;
        out_next.redraw_request = s2_redraw_reg;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cd_reg        <= 4'd0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                cd_reg <= cd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_inr_reg         <= in_inr;
            s1_addr_reg        <= in_addr;
            s1_new_level_reg   <= in_data.new_level;
            s1_level_valid_reg <= in_data.level_valid;
            s1_tick_reg        <= in_data.decay_tick;
            s1_last_reg        <= in_data.frame_last;

            s2_inr_reg    <= s1_inr_reg;
            s2_addr_reg   <= s1_addr_reg;
            s2_lvl_reg    <= lvl_next;
            s2_pk_reg     <= pk_next;
            s2_spd_reg    <= spd_next;
            s2_grow_reg   <= grow_next;
            s2_prod_reg   <= prod_next;
            s2_redraw_reg <= redraw_next;

            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the spectrum bar peak hold meter
// Drives bar beats through the valid/stall channel and updates a cycle-free
// model of the level, peak and peak speed of every bar. Each result beat is
// compared field by field with the oldest prediction. The bench switches
// between fall, growth and redraw settings and between idling patterns.
// ----------------------------------------------------------------------------
module testbench;

    import sbphd_pkg::*;

    localparam int NUM_BARS = 75;
    localparam int FRAC     = 12;
    localparam int QW       = 8 + FRAC;
    localparam longint unsigned QMAX = (64'd1 << QW) - 64'd1;
    localparam longint unsigned QONE = 64'd1 << FRAC;

    // Index 3 decodes to no register; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 8;
    localparam int RANDOM_BEATS   = 1640;
    localparam int RANDOM_SEGS    = 8;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    spectrum_bar_peak_hold_decay_top #(
        .NUM_BARS  (NUM_BARS),
        .FRAC_BITS (FRAC)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Meter model: its own copy of every bar and of the settings
    // ------------------------------------------------------------------
    longint unsigned bar_lvl [NUM_BARS];
    longint unsigned bar_pk  [NUM_BARS];
    longint unsigned bar_spd [NUM_BARS];
    logic [3:0]      redraw_cnt = '0;
    logic [2:0]      lvl_sel    = '0;
    logic [2:0]      pk_sel     = '0;
    logic [1:0]      rd_sel     = '0;

    out_item_t heights_q [$];   // predicted heights, oldest first

    int errors       = 0;
    int beats_sent   = 0;
    int beats_seen   = 0;
    int redraws_seen = 0;
    int stray_beats  = 0;
    int speed_sats   = 0;
    int reg_writes   = 0;
    int in_idle_pct  = 0;
    int out_stall_pct = 0;

    // Level fall per tick, hundredths of one bar unit; selects above four clamp
    function automatic longint unsigned fall_pct(input logic [2:0] s);
        case (s)
            3'd0:    return 34;
            3'd1:    return 50;
            3'd2:    return 100;
            3'd3:    return 130;
            default: return 160;
        endcase
    endfunction

    // Peak speed growth per decay step, hundredths
    function automatic longint unsigned grow_pct(input logic [2:0] s);
        case (s)
            3'd0:    return 120;
            3'd1:    return 130;
            3'd2:    return 140;
            3'd3:    return 150;
            default: return 160;
        endcase
    endfunction

    function automatic logic [3:0] delay_ticks(input logic [1:0] s);
        case (s)
            2'd0:    return 4'd1;
            2'd1:    return 4'd2;
            2'd2:    return 4'd4;
            default: return 4'd8;
        endcase
    endfunction

    // Peak drops by its speed, never under the level; speed then grows
    function automatic void peak_falloff(input int b);
        longint unsigned p;
        longint unsigned s;
        longint unsigned ns;
        p = bar_pk[b];
        s = bar_spd[b];
        p = (s >= p) ? 64'd0 : p - s;
        if (p < bar_lvl[b])
            p = bar_lvl[b];
        bar_pk[b] = p;
        ns = (s * grow_pct(pk_sel) + 64'(HALF_HUNDRED)) / 64'(HUNDRED);
        if (ns > QMAX)
        begin
            ns = QMAX;
            speed_sats++;
        end
        bar_spd[b] = ns;
    endfunction

    // One bar beat: update the model and return the heights it should report
    function automatic out_item_t meter_update(input in_item_t it);
        out_item_t       r;
        longint unsigned nl;
        longint unsigned rate;
        int              b;
        r  = '0;
        nl = 64'(it.new_level);
        nl = nl << FRAC;
        if (it.bar_index < NUM_BARS)
        begin
            b = int'(it.bar_index);
            if (it.level_valid && nl > bar_lvl[b])
            begin
                bar_lvl[b] = nl;
                if (nl > bar_pk[b])
                begin
                    bar_pk[b]  = nl;
                    bar_spd[b] = (QONE + 64'(HALF_HUNDRED)) / 64'(HUNDRED);
                end
                else if (bar_pk[b] > 0)
                    peak_falloff(b);
            end
            else if (it.decay_tick)
            begin
                if (bar_lvl[b] > 0)
                begin
                    rate = (fall_pct(lvl_sel) * QONE + 64'(HALF_HUNDRED)) / 64'(HUNDRED);
                    bar_lvl[b] = (rate >= bar_lvl[b]) ? 64'd0 : bar_lvl[b] - rate;
                end
                if (bar_pk[b] > 0)
                    peak_falloff(b);
            end
            r.bar_height  = 8'(bar_lvl[b] >> FRAC);
            r.peak_height = 8'(bar_pk[b] >> FRAC);
        end
        else
            stray_beats++;
        // frame-end tick runs the redraw countdown whatever the bar
        if (it.frame_last && it.decay_tick)
        begin
            if (redraw_cnt == 4'd0)
            begin
                r.redraw_request = 1'b1;
                redraw_cnt = delay_ticks(rd_sel);
            end
            redraw_cnt = redraw_cnt - 4'd1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall, checking and the watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < out_stall_pct);

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Every accepted result beat is matched against the oldest prediction
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_seen++;
            if (out_data.redraw_request)
                redraws_seen++;
            if (heights_q.size() == 0)
            begin
                $display("[%0t] result beat with nothing outstanding", $realtime);
                errors++;
            end
            else
            begin
                want = heights_q.pop_front();
                if (out_data.bar_height !== want.bar_height)
                    report_mismatch("bar_height", int'(out_data.bar_height),
                                    int'(want.bar_height));
                if (out_data.peak_height !== want.peak_height)
                    report_mismatch("peak_height", int'(out_data.peak_height),
                                    int'(want.peak_height));
                if (out_data.redraw_request !== want.redraw_request)
                    report_mismatch("redraw_request", int'(out_data.redraw_request),
                                    int'(want.redraw_request));
            end
        end
    end

    // Ends a hung run: counts cycles in which no beat moves on any channel
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no beat for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------

    // Valid is left high after the beat; only an idle gap or a drain drops it
    task automatic send_bar(input in_item_t it);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        heights_q.push_back(meter_update(it));
        beats_sent++;
    endtask

    task automatic send_fields(input int bar, input int lvl, input bit vld,
                               input bit tick, input bit last);
        in_item_t it;
        it.bar_index   = 7'(bar);
        it.new_level   = 8'(lvl);
        it.level_valid = vld;
        it.decay_tick  = tick;
        it.frame_last  = last;
        send_bar(it);
    endtask

    // Sender holds off until every predicted result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (heights_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_LEVEL_FALL:  lvl_sel = val;
            CFG_PEAK_FALL:   pk_sel  = val;
            CFG_REDRAW_RATE: rd_sel  = val[1:0];
            default:         ;
        endcase
    endtask

    task automatic set_meter(input logic [2:0] lf, input logic [2:0] pf, input logic [1:0] rr);
        drain_results();
        write_reg(CFG_LEVEL_FALL, lf);
        write_reg(CFG_PEAK_FALL, pf);
        write_reg(CFG_REDRAW_RATE, {1'b0, rr});
    endtask

    // Idling patterns: none, sender gaps, receiver stalls, a little of both
    task automatic set_idling(input int phase);
        case (phase % 4)
            0:
            begin
                in_idle_pct   = 0;
                out_stall_pct = 0;
            end
            1:
            begin
                in_idle_pct   = 58;
                out_stall_pct = 0;
            end
            2:
            begin
                in_idle_pct   = 0;
                out_stall_pct = 58;
            end
            default:
            begin
                in_idle_pct   = 14;
                out_stall_pct = 14;
            end
        endcase
    endtask

    // Random beat: a few hot bars take most traffic so peaks decay for long
    // runs and speeds reach saturation; a few beats address missing bars.
    function automatic in_item_t random_bar();
        in_item_t it;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 55)
            it.bar_index = 7'($urandom_range(3));
        else if (pick < 95)
            it.bar_index = 7'($urandom_range(NUM_BARS - 1));
        else
            it.bar_index = 7'($urandom_range(127, NUM_BARS));
        it.new_level   = 8'($urandom_range(255));
        it.level_valid = ($urandom_range(99) < 55);
        it.decay_tick  = ($urandom_range(99) < 40);
        it.frame_last  = ($urandom_range(99) < 15);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Freshly reset bars read as zero; a missing bar reports zero heights
    task automatic test_quiet_bars();
        send_fields(0, 0, 1'b0, 1'b0, 1'b0);
        send_fields(NUM_BARS - 1, 255, 1'b0, 1'b0, 1'b0);
        send_fields(127, 255, 1'b1, 1'b1, 1'b0);
        send_fields(NUM_BARS, 200, 1'b1, 1'b0, 1'b0);
    endtask

    // Higher data captures level and peak; equal or lower data is ignored
    task automatic test_level_capture();
        send_fields(0, 255, 1'b1, 1'b0, 1'b0);
        send_fields(NUM_BARS - 1, 1, 1'b1, 1'b0, 1'b0);
        send_fields(0, 100, 1'b1, 1'b0, 1'b0);
        send_fields(0, 255, 1'b1, 1'b0, 1'b0);
        send_fields(0, 200, 1'b0, 1'b0, 1'b0);
    endtask

    // Ticks drop level and peak; higher data below the peak still decays it;
    // a small level falls to the zero floor while the peak decays above it
    task automatic test_falloff();
        repeat (3) send_fields(0, 0, 1'b0, 1'b1, 1'b0);
        send_fields(0, 254, 1'b1, 1'b1, 1'b0);
        send_fields(0, 10, 1'b1, 1'b1, 1'b0);
        repeat (3) send_fields(NUM_BARS - 1, 0, 1'b0, 1'b1, 1'b0);
    endtask

    // Frame-end ticks run the countdown, also on a missing bar; frame end
    // without a tick leaves it alone
    task automatic test_redraw();
        send_fields(5, 0, 1'b0, 1'b1, 1'b1);
        send_fields(5, 0, 1'b0, 1'b1, 1'b1);
        send_fields(5, 0, 1'b0, 1'b0, 1'b1);
        send_fields(100, 0, 1'b0, 1'b1, 1'b1);
        set_meter(3'd4, 3'd4, 2'd3);
        repeat (3) send_fields(6, 0, 1'b0, 1'b1, 1'b1);
    endtask

    // Every select value, those above four included, plus the spare index
    task automatic test_setting_sweep();
        for (int v = 0; v < 8; v++)
        begin
            set_meter(3'(v), 3'(7 - v), 2'(v));
            write_reg(CFG_SPARE, 3'(v));
            set_idling(v);
            repeat (20) send_bar(random_bar());
        end
    endtask

    // Long random run across settings and idling patterns, with the odd
    // full pause until every result is back
    task automatic test_random_traffic();
        for (int seg = 0; seg < RANDOM_SEGS; seg++)
        begin
            if (seg == 0)
                set_meter(3'd0, 3'd0, 2'd0);
            else if (seg == RANDOM_SEGS - 1)
                set_meter(3'd4, 3'd4, 2'd3);
            else
                set_meter(3'($urandom_range(7)), 3'($urandom_range(7)),
                          2'($urandom_range(3)));
            set_idling(seg);
            for (int n = 0; n < RANDOM_BEATS / RANDOM_SEGS; n++)
            begin
                if ($urandom_range(149) == 0)
                    drain_results();
                send_bar(random_bar());
            end
        end
    endtask

    initial
    begin
        for (int b = 0; b < NUM_BARS; b++)
        begin
            bar_lvl[b] = 0;
            bar_pk[b]  = 0;
            bar_spd[b] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0);
        test_quiet_bars();
        test_level_capture();
        test_falloff();
        test_redraw();
        test_setting_sweep();
        test_random_traffic();

        // wait out the last results, then a short tail for stray beats
        in_valid <= 1'b0;
        while (heights_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d bar beats (%0d to missing bars), %0d results, %0d redraws,",
                 beats_sent, stray_beats, beats_seen, redraws_seen);
        $display("%0d register writes and %0d saturated peak speeds; %0d mismatches.",
                 reg_writes, speed_sats, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sbphd_pkg.sv
hw/rtl/sbphd_store.sv
hw/rtl/spectrum_bar_peak_hold_decay_top.sv
sim/testbench.sv
